// ----- rtl/cldw_pkg.sv -----
`default_nettype none

package cldw_pkg;

   // Field widths of the request and response words
   localparam int ROW_W       = 2;
   localparam int COLUMN_W    = 6;
   localparam int NUMBER_W    = 16;
   localparam int DIGIT_CNT_W = 3;
   localparam int BYTE_W      = 8;

   // Number of decimal digits held and emitted at most
   localparam int MAX_DIGITS  = 5;
   localparam int BCD_W       = 4 * MAX_DIGITS;
   localparam int DIG_W       = $clog2(MAX_DIGITS + 1);
   localparam int BIT_CNT_W   = $clog2(NUMBER_W);

   // Display constants
   localparam logic [BYTE_W-1:0]  CMD_SET_CURSOR = 8'h80;
   localparam logic [BYTE_W-1:0]  ROW_TWO_OFFSET = 8'h40;
   localparam logic [BYTE_W-1:0]  ASCII_ZERO     = 8'h30;
   localparam logic [BYTE_W-1:0]  COLUMN_ADJUST  = 8'hFF;
   localparam logic [ROW_W-1:0]   ROW_FIRST      = 2'd1;

   // Shift-and-add-3 correction for a radix-10 digit
   localparam int         RADIX        = 10;
   localparam logic [3:0] DABBLE_LIMIT = 4'(RADIX / 2);
   localparam logic [3:0] DABBLE_ADD   = 4'((16 - RADIX) / 2);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_ALIGN,
      ST_CMD,
      ST_DIGITS
   } state_type;

   // Commands to the conversion shift register
   typedef struct packed {
      logic load;
      logic dabble;
      logic shift_digit;
   } bcd_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/char_lcd_decimal_number_writer.sv -----
// Sequence: an accepted request is converted bit-serially to BCD, the top digit is
//    aligned past MAX_DIGITS - n leading digits, n being the saturated digit count, then
//    the set-cursor command word goes out, then one digit word a cycle while the output is free.
// A new request is taken only after the last word of the previous one is registered.
// Reset: synchronous, active high; clears the sequencer and the output valid flag.
`default_nettype none

module char_lcd_decimal_number_writer
   import cldw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] row_select, [7:2] column, [23:8] number, [26:24] digit_count, [31:27] zero
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] bus_byte
   output logic [7:0]       rsp_tdata,
   // [0] is_data
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast
);

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]       dig_cnt_ff, dig_cnt_in;
   logic [DIG_W-1:0]       count_ff, count_in;
   logic [BYTE_W-1:0]      cmd_ff, cmd_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                   out_user_ff, out_user_in;
   logic                   out_last_ff, out_last_in;

   logic [ROW_W-1:0]       row_select;
   logic [COLUMN_W-1:0]    column;
   logic [NUMBER_W-1:0]    number;
   logic [DIGIT_CNT_W-1:0] digit_count;
   logic [BYTE_W-1:0]      addr;
   logic [DIG_W-1:0]       count_sat;
   logic                   in_accept;
   logic                   out_free;
   logic [3:0]             top_digit;
   bcd_ctrl_type           bcd_ctrl;

   // request word unpacking
   assign row_select  = req_tdata[1:0];
   assign column      = req_tdata[7:2];
   assign number      = req_tdata[23:8];
   assign digit_count = req_tdata[26:24];

   assign in_accept = req_tvalid && req_tready;
   assign out_free  = !out_valid_ff || rsp_tready;

   // cursor address, formed modulo 256
   always_comb begin
      addr = BYTE_W'({2'b00, column}) + COLUMN_ADJUST;
      if (row_select != ROW_FIRST) begin
         addr = addr + ROW_TWO_OFFSET;
      end
   end

   // saturate the digit count
   always_comb begin
      if (int'(digit_count) > MAX_DIGITS) begin
         count_sat = DIG_W'(MAX_DIGITS);
      end else begin
         count_sat = DIG_W'(digit_count);
      end
   end

   cldw_bcd_shifter u_bcd (
      .clock     (clock),
      .ctrl      (bcd_ctrl),
      .number    (number),
      .top_digit (top_digit)
   );

   // sequencer: convert, align top digit, then command and digit words
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      out_byte_in  = out_byte_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      bcd_ctrl     = '0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               bcd_ctrl.load = 1'b1;
               bit_cnt_in    = BIT_CNT_W'(NUMBER_W - 1);
               count_in      = count_sat;
               cmd_in        = CMD_SET_CURSOR | addr;
               state_in      = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_ctrl.dabble = 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_W'(MAX_DIGITS) - count_ff;
               state_in   = ST_ALIGN;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_ALIGN: begin
            if (dig_cnt_ff == '0) begin
               state_in = ST_CMD;
            end else begin
               bcd_ctrl.shift_digit = 1'b1;
               dig_cnt_in           = dig_cnt_ff - 1'b1;
            end
         end
         ST_CMD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_user_in  = 1'b0;
               out_byte_in  = cmd_ff;
               out_last_in  = (count_ff == '0);
               dig_cnt_in   = count_ff;
               state_in     = (count_ff == '0) ? ST_IDLE : ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_user_in          = 1'b1;
               out_byte_in          = ASCII_ZERO | {4'b0000, top_digit};
               out_last_in          = (dig_cnt_ff == DIG_W'(1));
               bcd_ctrl.shift_digit = 1'b1;
               dig_cnt_in           = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      count_ff    <= count_in;
      cmd_ff      <= cmd_in;
      out_byte_ff <= out_byte_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tuser[0] = out_user_ff;
   assign rsp_tlast    = out_last_ff;

`ifndef SYNTHESIS
   // an accepted request starts a full-length conversion
   a_start_convert: assert property (@(posedge clock) disable iff (reset)
      in_accept |=> (state_ff == ST_CONVERT) && (bit_cnt_ff == BIT_CNT_W'(NUMBER_W - 1)))
      else $error("conversion not started after request");

   // the command word goes out from the command state only
   a_cmd_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMD) && out_free |=> rsp_tvalid && !rsp_tuser[0])
      else $error("command word not loaded");

   // a digit word carries an ASCII decimal digit
   a_digit_ascii: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) && out_free
      |=> rsp_tvalid && rsp_tuser[0] && (rsp_tdata[7:4] == 4'h3) && (rsp_tdata[3:0] <= 4'd9))
      else $error("digit word is not a decimal character");

   // no request is taken while a word of the previous one remains to be built
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) && (dig_cnt_ff != DIG_W'(1)) |=> !req_tready)
      else $error("request accepted mid-sequence");
`endif

endmodule

`default_nettype wire

// ----- rtl/cldw_bcd_shifter.sv -----
`default_nettype none

module cldw_bcd_shifter
   import cldw_pkg::*;
(
   input  wire logic                clock,
   input  wire bcd_ctrl_type        ctrl,
   input  wire logic [NUMBER_W-1:0] number,
   output logic      [3:0]          top_digit
);

   logic [NUMBER_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BCD_W-1:0]    adj;

   // add-3 correction on every digit, digits are independent
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= DABBLE_LIMIT) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + DABBLE_ADD;
         end else begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // one binary bit a cycle into the BCD register while dabble is set, one digit a cycle out while shift_digit is set
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = number;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = bin_ff << 1;
         bcd_in = BCD_W'({adj, bin_ff[NUMBER_W-1]});
      end else if (ctrl.shift_digit) begin
         bcd_in = bcd_ff << 4;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ----- tb/char_lcd_decimal_number_writer_tb.sv -----
`timescale 1ns / 1ps

module char_lcd_decimal_number_writer_tb;
   import cldw_pkg::*;

   // Register-select codes of an LCD write
   localparam logic WR_COMMAND = 1'b0;
   localparam logic WR_DATA    = 1'b1;

   localparam int RANDOM_REQUESTS = 300;
   localparam int PAUSE_EVERY     = 100;
   localparam int LONG_HOLD       = 400;
   localparam int HOLD_AFTER      = 150;
   localparam int SETTLE_CYCLES   = 48;
   localparam int CYCLE_LIMIT     = 250000;

   // Request word as it sits on req_tdata, lowest field last
   typedef struct packed {
      logic [4:0]             zero;
      logic [DIGIT_CNT_W-1:0] digit_count;
      logic [NUMBER_W-1:0]    number;
      logic [COLUMN_W-1:0]    column;
      logic [ROW_W-1:0]       row_select;
   } req_word_type;

   // Pending entry: a request word, or a pause until the display side is drained
   typedef struct packed {
      logic         pause;
      req_word_type word;
   } lcd_request_type;

   typedef struct packed {
      logic              is_data;
      logic [BYTE_W-1:0] bus_byte;
      logic              last_write;
   } lcd_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   lcd_request_type pending_requests[$];
   lcd_write_type   expected_writes[$];
   lcd_write_type   want;
   lcd_request_type next_request;
   int              errors      = 0;
   int              words_seen  = 0;
   int              cycle_count = 0;
   int              burst_left  = 0;
   int              gap_left    = 0;
   int              hold_left   = 0;
   int              stall_mode  = 0;
   bit              long_hold_done = 1'b0;

   char_lcd_decimal_number_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Expected bus writes for one request: cursor command, then digits MSD first
   task automatic predict_lcd_writes(input req_word_type word);
      logic [BYTE_W-1:0]   addr;
      logic [NUMBER_W-1:0] value;
      logic [3:0]          digits [MAX_DIGITS];
      lcd_write_type       wr;
      int                  count;
      count = word.digit_count;
      if (count > MAX_DIGITS) count = MAX_DIGITS;
      // one-based column; column zero wraps within the byte
      addr = BYTE_W'(word.column) + COLUMN_ADJUST;
      if (word.row_select != ROW_FIRST) addr = addr + ROW_TWO_OFFSET;
      wr.is_data    = WR_COMMAND;
      wr.bus_byte   = CMD_SET_CURSOR | addr;
      wr.last_write = (count == 0);
      expected_writes.push_back(wr);
      value = word.number;
      for (int i = 0; i < count; i++) begin
         digits[i] = 4'(value % RADIX);
         value     = value / RADIX;
      end
      for (int i = count - 1; i >= 0; i--) begin
         wr.is_data    = WR_DATA;
         wr.bus_byte   = ASCII_ZERO + BYTE_W'(digits[i]);
         wr.last_write = (i == 0);
         expected_writes.push_back(wr);
      end
   endtask

   task automatic queue_request(input logic [ROW_W-1:0] row, input logic [COLUMN_W-1:0] col,
                                input logic [NUMBER_W-1:0] num,
                                input logic [DIGIT_CNT_W-1:0] cnt);
      lcd_request_type item;
      item                  = '0;
      item.word.row_select  = row;
      item.word.column      = col;
      item.word.number      = num;
      item.word.digit_count = cnt;
      pending_requests.push_back(item);
   endtask

   task automatic queue_pause();
      lcd_request_type item;
      item       = '0;
      item.pause = 1'b1;
      pending_requests.push_back(item);
   endtask

   // Stimulus and end of run
   initial begin
      logic [NUMBER_W-1:0] num;
      // directed: field extremes, wrap of column zero, row codes, saturation
      queue_request(2'd1, 6'd1,  16'd0,     3'd0);
      queue_request(2'd2, 6'd1,  16'd12345, 3'd5);
      queue_request(2'd0, 6'd40, 16'd65535, 3'd5);
      queue_request(2'd3, 6'd63, 16'd65535, 3'd7);
      queue_request(2'd1, 6'd0,  16'd42,    3'd3);
      queue_request(2'd2, 6'd0,  16'd42,    3'd3);
      queue_request(2'd1, 6'd17, 16'd7,     3'd1);
      queue_request(2'd2, 6'd21, 16'd65535, 3'd2);
      queue_request(2'd1, 6'd5,  16'd7,     3'd5);
      queue_request(2'd1, 6'd8,  16'd100,   3'd4);
      queue_request(2'd2, 6'd32, 16'd9,     3'd6);
      queue_request(2'd1, 6'd1,  16'd1,     3'd1);
      queue_request(2'd2, 6'd40, 16'd10000, 3'd5);
      queue_request(2'd0, 6'd2,  16'd65535, 3'd0);
      queue_request(2'd3, 6'd31, 16'd99,    3'd2);
      queue_request(2'd1, 6'd42, 16'd0,     3'd5);
      queue_request(2'd2, 6'd63, 16'd54321, 3'd7);
      queue_request(2'd3, 6'd0,  16'd32768, 3'd4);
      queue_pause();
      // random
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if ($urandom_range(0, 3) == 0) num = 16'($urandom_range(0, 99));
         else num = 16'($urandom_range(0, 65535));
         queue_request(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), num,
                       3'($urandom_range(0, 7)));
         if (n % PAUSE_EVERY == PAUSE_EVERY - 1) queue_pause();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("** char_lcd_decimal_number_writer: PASSED **");
      end else begin
         $display("** char_lcd_decimal_number_writer: FAILED **");
      end
      $finish;
   end

   // Request driver: bursts and gaps, pauses wait for all writes to return
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_lcd_writes(req_word_type'(req_tdata));
         if (req_tvalid && !req_tready) begin
            // word still on offer
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_requests[0].pause) begin
            req_tvalid <= 1'b0;
            if (expected_writes.size() == 0) void'(pending_requests.pop_front());
         end else begin
            next_request = pending_requests.pop_front();
            req_tdata  <= next_request.word;
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  // long run with no idling
                  gap_left   = 0;
                  burst_left = $urandom_range(30, 60);
               end else begin
                  gap_left   = $urandom_range(1, 25);
                  burst_left = $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Write monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (expected_writes.size() == 0) begin
               errors++;
               $display("%0t: unexpected word: is_data %0b byte %02h last %0b",
                        $time, rsp_tuser[0], rsp_tdata, rsp_tlast);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_tuser[0] !== want.is_data) begin
                  errors++;
                  $display("%0t: is_data expected %0b actual %0b",
                           $time, want.is_data, rsp_tuser[0]);
               end
               if (rsp_tdata !== want.bus_byte) begin
                  errors++;
                  $display("%0t: bus_byte expected %02h actual %02h",
                           $time, want.bus_byte, rsp_tdata);
               end
               if (rsp_tlast !== want.last_write) begin
                  errors++;
                  $display("%0t: last_write expected %0b actual %0b",
                           $time, want.last_write, rsp_tlast);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && words_seen >= HOLD_AFTER) begin
            // long hold-off so the block backs up into its input
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            if (cycle_count % 50 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= (cycle_count % 7 < 4);
               end
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** char_lcd_decimal_number_writer: FAILED **");
         $finish;
      end
   end

endmodule

// ----- files.f -----
rtl/cldw_pkg.sv
rtl/cldw_bcd_shifter.sv
rtl/char_lcd_decimal_number_writer.sv
tb/char_lcd_decimal_number_writer_tb.sv
